// ===== rtl/core/lpse_pkg.sv =====
// ----------------------------------------------------------------------------
// lpse_pkg
// Shared types and constants for the single-wire LED pixel encoder.
// ----------------------------------------------------------------------------
package lpse_pkg;

    // Line phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_GAP  = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } phase_t;

    // Result status codes
    localparam logic [1:0] STATUS_TICK    = 2'd0;
    localparam logic [1:0] STATUS_ACCEPT  = 2'd1;
    localparam logic [1:0] STATUS_REFUSED = 2'd2;

    // Input action codes
    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_TICK  = 1'b1;

    // Slot codes
    localparam logic [1:0] SLOT_WHITE = 2'd0;
    localparam logic [1:0] SLOT_RED   = 2'd1;
    localparam logic [1:0] SLOT_GREEN = 2'd2;
    localparam logic [1:0] SLOT_BLUE  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_ONE_HIGH  = 3'd0;
    localparam logic [2:0] CFG_ONE_LOW   = 3'd1;
    localparam logic [2:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [2:0] CFG_ZERO_LOW  = 3'd3;
    localparam logic [2:0] CFG_GAP       = 3'd4;
    localparam logic [2:0] CFG_ORDER     = 3'd5;
    localparam logic [2:0] CFG_COUNT     = 3'd6;

    // Register reset values
    localparam logic [11:0] RST_ONE_HIGH  = 12'd90;
    localparam logic [11:0] RST_ONE_LOW   = 12'd45;
    localparam logic [11:0] RST_ZERO_HIGH = 12'd40;
    localparam logic [11:0] RST_ZERO_LOW  = 12'd95;
    localparam logic [15:0] RST_GAP       = 16'd9600;
    localparam logic [7:0]  RST_ORDER     = 8'd54;
    localparam logic [2:0]  RST_COUNT     = 3'd4;

    localparam logic [2:0]  MAX_SLOTS     = 3'd4;

    // A pulse length of zero is raised to a length of one tick
    function automatic logic [15:0] at_least_one(input logic [11:0] v);
        at_least_one = (v == 12'd0) ? 16'd1 : {4'd0, v};
    endfunction

endpackage

// ===== rtl/core/led_pixel_serial_encoder_core.sv =====
// ----------------------------------------------------------------------------
// led_pixel_serial_encoder_core
// Encodes pixels into single-wire pulse trains; each tick item is one
// unit of the line timing.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Signals                              | Content
//  ---------+-----+--------------------------------------+------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata s_tuser    | pixel or tick item
//  m_*      | out | m_tvalid m_tready m_tdata m_tuser    | line level and status
//  cfg_*    | in  | cfg_valid cfg_ready cfg_index cfg_data | register writes
//
//  One item per cycle: the line state is updated at acceptance and the
//  result sits in an output register. An item is taken whenever that
//  register is empty or being drained in the same cycle, so m_tready
//  low stalls input by one register stage only. Reset (rst_n, async)
//  sets idle phase, clears out_valid and loads default config registers.
// ----------------------------------------------------------------------------
module led_pixel_serial_encoder_core
    import lpse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic [1:0]  s_tuser,   // action[0], frame_start[1]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // line[0], busy_res[1], zero[7:2]
    output logic [1:0]  m_tuser,   // status[1:0]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers
    logic [11:0] one_high_reg, one_low_reg, zero_high_reg, zero_low_reg;
    logic [15:0] gap_reg;
    logic [7:0]  order_reg;
    logic [2:0]  count_reg;

    // Line state
    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [31:0] shift_reg, shift_next;
    logic [5:0]  bits_reg, bits_next;
    logic        bit_reg, bit_next;

    // Result register
    logic        out_valid_reg;
    logic        line_reg, line_next;
    logic        busy_reg, busy_next;
    logic [1:0]  status_reg, status_next;

    logic        accept;

    // Input item fields
    logic        action;
    logic        frame_start;
    logic [7:0]  red, green, blue;

    // Pixel assembly
    logic [2:0]  slots;
    logic [31:0] word;
    logic [15:0] tick_dec;

    // Start-of-bit helper inputs
    logic        do_begin;
    logic [31:0] src_shift;
    logic [5:0]  src_bits;

    assign action      = s_tuser[0];
    assign frame_start = s_tuser[1];
    assign red         = s_tdata[7:0];
    assign green       = s_tdata[15:8];
    assign blue        = s_tdata[23:16];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, busy_reg, line_reg};
    assign m_tuser  = status_reg;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= RST_ONE_HIGH;
            one_low_reg   <= RST_ONE_LOW;
            zero_high_reg <= RST_ZERO_HIGH;
            zero_low_reg  <= RST_ZERO_LOW;
            gap_reg       <= RST_GAP;
            order_reg     <= RST_ORDER;
            count_reg     <= RST_COUNT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ONE_HIGH:  one_high_reg  <= cfg_data[11:0];
                CFG_ONE_LOW:   one_low_reg   <= cfg_data[11:0];
                CFG_ZERO_HIGH: zero_high_reg <= cfg_data[11:0];
                CFG_ZERO_LOW:  zero_low_reg  <= cfg_data[11:0];
                CFG_GAP:       gap_reg       <= cfg_data;
                CFG_ORDER:     order_reg     <= cfg_data[7:0];
                CFG_COUNT:     count_reg     <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    // Colour bytes in slot order, slot 0 in the top byte
    always_comb
    begin
        logic [1:0] code;
        logic [7:0] byte_val;
        slots = (count_reg > MAX_SLOTS) ? MAX_SLOTS : count_reg;
        word  = 32'd0;
        for (int k = 0; k < 4; k++)
        begin
            code = order_reg[2*k +: 2];
            case (code)
                SLOT_RED:   byte_val = red;
                SLOT_GREEN: byte_val = green;
                SLOT_BLUE:  byte_val = blue;
                default:    byte_val = 8'd0;
            endcase
            if (3'(k) < slots)
                word[8*(3-k) +: 8] = byte_val;
        end
    end

    assign tick_dec = tick_reg - 16'd1;

    // Next line state
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        bit_next    = bit_reg;
        status_next = STATUS_TICK;
        do_begin    = 1'b0;
        src_shift   = shift_reg;
        src_bits    = bits_reg;

        if (action == ACTION_PIXEL)
        begin
            if (phase_reg != PH_IDLE)
            begin
                status_next = STATUS_REFUSED;
            end
            else
            begin
                status_next = STATUS_ACCEPT;
                shift_next  = word;
                bits_next   = {slots, 3'd0};
                if (frame_start && gap_reg != 16'd0)
                begin
                    phase_next = PH_GAP;
                    tick_next  = gap_reg;
                end
                else
                begin
                    do_begin  = 1'b1;
                    src_shift = word;
                    src_bits  = {slots, 3'd0};
                end
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_next = tick_dec;
            if (tick_dec == 16'd0)
            begin
                if (phase_reg == PH_HIGH)
                begin
                    phase_next = PH_LOW;
                    tick_next  = at_least_one(bit_reg ? one_low_reg : zero_low_reg);
                end
                else
                begin
                    do_begin = 1'b1;
                end
            end
        end

        // Start the next bit, or go idle when none is left
        if (do_begin)
        begin
            if (src_bits == 6'd0)
            begin
                phase_next = PH_IDLE;
                tick_next  = 16'd0;
                shift_next = src_shift;
                bits_next  = src_bits;
            end
            else
            begin
                bit_next   = src_shift[31];
                shift_next = {src_shift[30:0], 1'b0};
                bits_next  = src_bits - 6'd1;
                phase_next = PH_HIGH;
                tick_next  = at_least_one(src_shift[31] ? one_high_reg : zero_high_reg);
            end
        end

        line_next = (phase_next == PH_HIGH);
        busy_next = (phase_next != PH_IDLE);
    end

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 16'd0;
            shift_reg <= 32'd0;
            bits_reg  <= 6'd0;
            bit_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            bit_reg   <= bit_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_reg   <= line_next;
            busy_reg   <= busy_next;
            status_reg <= status_next;
        end
    end

endmodule
